// File: sv/arith_enc_pkg.sv
// ----------------------------------------------------------------------------
// arith_enc_pkg
// Types, constants and bit-serial step functions for the 16-bit arithmetic
// encoder core.
// ----------------------------------------------------------------------------
package arith_enc_pkg;

  localparam int unsigned CodeW  = 16;
  localparam int unsigned TotalW = 15;
  localparam int unsigned LowW   = 14;
  localparam int unsigned HighW  = 15;
  localparam int unsigned RangeW = CodeW + 1;
  localparam int unsigned ProdW  = RangeW + HighW + 1;  // product plus spare msb
  localparam int unsigned AccW   = RangeW + 1;

  localparam logic [CodeW-1:0]  CodeTop      = 16'hFFFF;
  localparam logic [CodeW-1:0]  CodeHalf     = 16'h8000;
  localparam logic [CodeW-1:0]  CodeQuarter  = 16'h4000;
  localparam logic [TotalW-1:0] TotalDefault = 15'd1;

  typedef struct packed {
    logic [LowW-1:0]  cum_low;
    logic [HighW-1:0] cum_high;
  } in_item_t;

  typedef struct packed {
    logic             code_bit;
    logic [CodeW-1:0] follow_count;
    logic             last;
  } out_item_t;

  typedef struct packed {
    logic [TotalW-1:0] rem;
    logic [ProdW-1:0]  p;
  } div_res_t;

  // One shift-add multiply step: multiplier sits in the low HighW bits,
  // partial sum in the upper bits, everything shifts right.
  function automatic logic [ProdW-1:0] mul_step(logic [ProdW-1:0] p,
                                                logic [RangeW-1:0] rng);
    logic [AccW-1:0] sum;
    sum = p[ProdW-1:HighW] + (p[0] ? {1'b0, rng} : {AccW{1'b0}});
    return {1'b0, sum, p[HighW-1:1]};
  endfunction

  // One restoring divide step: dividend msb shifts out, quotient bit in at lsb.
  function automatic div_res_t div_step(logic [ProdW-1:0] p,
                                        logic [TotalW-1:0] rem,
                                        logic [TotalW-1:0] dv);
    div_res_t        res;
    logic [TotalW:0] trial;
    logic [TotalW:0] diff;
    logic            ge;
    trial   = {rem, p[ProdW-2]};
    diff    = trial - {1'b0, dv};
    ge      = (trial >= {1'b0, dv});
    res.rem = ge ? diff[TotalW-1:0] : trial[TotalW-1:0];
    res.p   = {1'b0, p[ProdW-3:0], ge};
    return res;
  endfunction

endpackage

// File: sv/arith_encode_step_16bit_core.sv
// ----------------------------------------------------------------------------
// arith_encode_step_16bit_core
// Static-model 16-bit arithmetic encoder: narrows the code interval per symbol
// and emits renormalization bits with their deferred follow counts.
// ----------------------------------------------------------------------------
// One symbol at a time. After a transfer in, two bit-serial shift-add
// multipliers run, then two restoring dividers (one quotient bit per cycle,
// which sets most of the latency), then one step narrows the interval, then
// renormalization makes up to 16 passes plus a closing step. Each result
// waits in an output register, and passes that emit a bit hold while that
// register is still occupied. in_ready is high only between symbols. A zero
// total_count divides by one.
module arith_encode_step_16bit_core (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_valid,
  output logic                               in_ready,
  input  arith_enc_pkg::in_item_t            in_data,
  output logic                               out_valid,
  input  logic                               out_ready,
  output arith_enc_pkg::out_item_t           out_data,
  input  logic                               cfg_we,
  input  logic [arith_enc_pkg::TotalW-1:0]   cfg_wdata
);

  typedef enum logic [4:0] {
    S_IDLE   = 5'b00001,
    S_MUL    = 5'b00010,
    S_DIV    = 5'b00100,
    S_NARROW = 5'b01000,
    S_RENORM = 5'b10000
  } state_t;

  localparam int unsigned CodeW  = arith_enc_pkg::CodeW;
  localparam int unsigned TotalW = arith_enc_pkg::TotalW;
  localparam int unsigned RangeW = arith_enc_pkg::RangeW;
  localparam int unsigned ProdW  = arith_enc_pkg::ProdW;
  localparam int unsigned HighW  = arith_enc_pkg::HighW;
  localparam int unsigned LowW   = arith_enc_pkg::LowW;
  localparam int unsigned CntW   = 6;
  localparam logic [CntW-1:0] MulLast = CntW'(HighW - 1);
  localparam logic [CntW-1:0] DivLast = CntW'(ProdW - 2);

  state_t               state_r, state_nxt;
  logic [TotalW-1:0]    total_r, total_nxt;
  logic [CodeW-1:0]     low_r, low_nxt;
  logic [CodeW-1:0]     high_r, high_nxt;
  logic [CodeW-1:0]     pend_r, pend_nxt;
  logic [RangeW-1:0]    range_r, range_nxt;
  logic [ProdW-1:0]     plo_r, plo_nxt;
  logic [ProdW-1:0]     phi_r, phi_nxt;
  logic [TotalW-1:0]    rlo_r, rlo_nxt;
  logic [TotalW-1:0]    rhi_r, rhi_nxt;
  logic [CntW-1:0]      cnt_r, cnt_nxt;
  logic                 hold_v_r, hold_v_nxt;
  logic                 hold_bit_r, hold_bit_nxt;
  logic [CodeW-1:0]     hold_follow_r, hold_follow_nxt;
  logic                 out_valid_r, out_valid_nxt;
  arith_enc_pkg::out_item_t out_data_r, out_data_nxt;

  logic [TotalW-1:0]    divisor;
  arith_enc_pkg::div_res_t dres_lo, dres_hi;
  logic                 out_free;
  logic                 emit0, emit1, defer, stop;
  logic [CodeW-1:0]     sub_val, lo_sub, hi_sub;

  assign divisor  = (total_r == '0) ? arith_enc_pkg::TotalDefault : total_r;
  assign dres_lo  = arith_enc_pkg::div_step(plo_r, rlo_r, divisor);
  assign dres_hi  = arith_enc_pkg::div_step(phi_r, rhi_r, divisor);
  assign out_free = !out_valid_r || out_ready;

  // renormalization decode, in priority order
  assign emit0 = !high_r[CodeW-1];
  assign emit1 = !emit0 && low_r[CodeW-1];
  assign defer = !emit0 && !emit1 && low_r[CodeW-2] && !high_r[CodeW-2];
  assign stop  = cnt_r[4] || !(emit0 || emit1 || defer);

  always_comb begin
    sub_val = '0;
    if (emit1) begin
      sub_val = arith_enc_pkg::CodeHalf;
    end else if (defer) begin
      sub_val = arith_enc_pkg::CodeQuarter;
    end
  end

  assign lo_sub = low_r - sub_val;
  assign hi_sub = high_r - sub_val;

  always_comb begin
    state_nxt       = state_r;
    total_nxt       = cfg_we ? cfg_wdata : total_r;
    low_nxt         = low_r;
    high_nxt        = high_r;
    pend_nxt        = pend_r;
    range_nxt       = range_r;
    plo_nxt         = plo_r;
    phi_nxt         = phi_r;
    rlo_nxt         = rlo_r;
    rhi_nxt         = rhi_r;
    cnt_nxt         = cnt_r;
    hold_v_nxt      = hold_v_r;
    hold_bit_nxt    = hold_bit_r;
    hold_follow_nxt = hold_follow_r;
    out_valid_nxt   = out_valid_r && !out_ready;
    out_data_nxt    = out_data_r;

    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          range_nxt = RangeW'({1'b0, high_r} - {1'b0, low_r} + RangeW'(1));
          plo_nxt   = {{(ProdW-LowW){1'b0}}, in_data.cum_low};
          phi_nxt   = {{(ProdW-HighW){1'b0}}, in_data.cum_high};
          rlo_nxt   = '0;
          rhi_nxt   = '0;
          cnt_nxt   = '0;
          state_nxt = S_MUL;
        end
      end
      S_MUL: begin
        plo_nxt = arith_enc_pkg::mul_step(plo_r, range_r);
        phi_nxt = arith_enc_pkg::mul_step(phi_r, range_r);
        cnt_nxt = cnt_r + CntW'(1);
        if (cnt_r == MulLast) begin
          cnt_nxt   = '0;
          state_nxt = S_DIV;
        end
      end
      S_DIV: begin
        plo_nxt = dres_lo.p;
        rlo_nxt = dres_lo.rem;
        phi_nxt = dres_hi.p;
        rhi_nxt = dres_hi.rem;
        cnt_nxt = cnt_r + CntW'(1);
        if (cnt_r == DivLast) begin
          state_nxt = S_NARROW;
        end
      end
      S_NARROW: begin
        // quotients are in the low bits; only 16 of them survive the wrap
        low_nxt   = low_r + plo_r[CodeW-1:0];
        high_nxt  = low_r + phi_r[CodeW-1:0] - CodeW'(1);
        cnt_nxt   = '0;
        state_nxt = S_RENORM;
      end
      S_RENORM: begin
        if (stop) begin
          if (!hold_v_r) begin
            state_nxt = S_IDLE;
          end else if (out_free) begin
            out_valid_nxt             = 1'b1;
            out_data_nxt.code_bit     = hold_bit_r;
            out_data_nxt.follow_count = hold_follow_r;
            out_data_nxt.last         = 1'b1;
            hold_v_nxt                = 1'b0;
            state_nxt                 = S_IDLE;
          end
        end else if (defer || !hold_v_r || out_free) begin
          // previous bit is known not to be last once another one shows up
          if (!defer) begin
            if (hold_v_r) begin
              out_valid_nxt             = 1'b1;
              out_data_nxt.code_bit     = hold_bit_r;
              out_data_nxt.follow_count = hold_follow_r;
              out_data_nxt.last         = 1'b0;
            end
            hold_v_nxt      = 1'b1;
            hold_bit_nxt    = emit1;
            hold_follow_nxt = pend_r;
            pend_nxt        = '0;
          end else if (pend_r != arith_enc_pkg::CodeTop) begin
            pend_nxt = pend_r + CodeW'(1);
          end
          low_nxt  = {lo_sub[CodeW-2:0], 1'b0};
          high_nxt = {hi_sub[CodeW-2:0], 1'b1};
          cnt_nxt  = cnt_r + CntW'(1);
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      total_r     <= arith_enc_pkg::TotalDefault;
      low_r       <= '0;
      high_r      <= arith_enc_pkg::CodeTop;
      pend_r      <= '0;
      cnt_r       <= '0;
      hold_v_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      total_r     <= total_nxt;
      low_r       <= low_nxt;
      high_r      <= high_nxt;
      pend_r      <= pend_nxt;
      cnt_r       <= cnt_nxt;
      hold_v_r    <= hold_v_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    range_r       <= range_nxt;
    plo_r         <= plo_nxt;
    phi_r         <= phi_nxt;
    rlo_r         <= rlo_nxt;
    rhi_r         <= rhi_nxt;
    hold_bit_r    <= hold_bit_nxt;
    hold_follow_r <= hold_follow_nxt;
    out_data_r    <= out_data_nxt;
  end

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

// File: tb/tb_arith_encode_step_16bit_core.sv
// ----------------------------------------------------------------------------
// tb_arith_encode_step_16bit_core
// Self-checking bench for the 16-bit arithmetic encoder step. A bit-exact
// interval model predicts every emitted code bit and follow count at symbol
// transfer; results are compared in order. The run covers the reset divisor,
// a zero divisor, the field extremes, a long deferral run that builds up the
// follow count, and random symbol streams under several totals.
// ----------------------------------------------------------------------------
module tb_arith_encode_step_16bit_core;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int          StallLimit = 4000;
  localparam int          SettleCyc  = 100;
  localparam logic [15:0] CodeThreeQ = 16'hC000;

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       in_valid = 1'b0;
  logic       in_ready;
  arith_enc_pkg::in_item_t   in_data = '0;
  logic       out_valid;
  logic       out_ready = 1'b0;
  arith_enc_pkg::out_item_t  out_data;
  logic       cfg_we = 1'b0;
  logic [arith_enc_pkg::TotalW-1:0] cfg_wdata = '0;

  // encoder state as the bench tracks it
  logic [arith_enc_pkg::TotalW-1:0] total_cfg   = arith_enc_pkg::TotalDefault;
  logic [arith_enc_pkg::CodeW-1:0]  iv_low      = '0;
  logic [arith_enc_pkg::CodeW-1:0]  iv_high     = arith_enc_pkg::CodeTop;
  logic [arith_enc_pkg::CodeW-1:0]  follow_pend = '0;

  arith_enc_pkg::in_item_t   sym_q[$];     // symbols waiting for transfer
  arith_enc_pkg::out_item_t  code_q[$];    // predicted code bits, oldest first
  arith_enc_pkg::out_item_t  want_item;
  int         err_cnt = 0;
  int         stall_cnt = 0;
  int         cyc_cnt = 0;
  logic       calm;

  assign calm = (cyc_cnt >= 6000) && (cyc_cnt < 11000);

  arith_encode_step_16bit_core u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // Narrow the interval for one symbol, then renormalize and queue the bits.
  function automatic void narrow_interval(arith_enc_pkg::in_item_t sym);
    logic [16:0]                      span;
    logic [31:0]                      q_lo;
    logic [31:0]                      q_hi;
    logic [arith_enc_pkg::CodeW-1:0]  lo;
    logic [arith_enc_pkg::CodeW-1:0]  hi;
    logic [arith_enc_pkg::TotalW-1:0] dv;
    arith_enc_pkg::out_item_t         res;
    int                               n;
    int                               pass;
    dv   = (total_cfg == '0) ? 15'd1 : total_cfg;
    span = {1'b0, iv_high} - {1'b0, iv_low} + 17'd1;
    q_lo = (32'(span) * 32'(sym.cum_low)) / 32'(dv);
    q_hi = (32'(span) * 32'(sym.cum_high)) / 32'(dv);
    lo   = iv_low + q_lo[15:0];
    hi   = iv_low + q_hi[15:0] + arith_enc_pkg::CodeTop;
    n    = 0;
    for (pass = 0; pass < 16; pass++) begin
      if (hi < arith_enc_pkg::CodeHalf || lo >= arith_enc_pkg::CodeHalf) begin
        res.code_bit     = (lo >= arith_enc_pkg::CodeHalf) &&
                           !(hi < arith_enc_pkg::CodeHalf);
        res.follow_count = follow_pend;
        res.last         = 1'b0;
        code_q = {code_q, res};
        follow_pend = '0;
        n++;
        if (res.code_bit) begin
          lo = lo - arith_enc_pkg::CodeHalf;
          hi = hi - arith_enc_pkg::CodeHalf;
        end
      end else if (lo >= arith_enc_pkg::CodeQuarter && hi < CodeThreeQ) begin
        if (follow_pend != arith_enc_pkg::CodeTop) follow_pend = follow_pend + 16'd1;
        lo = lo - arith_enc_pkg::CodeQuarter;
        hi = hi - arith_enc_pkg::CodeQuarter;
      end else begin
        break;
      end
      lo = lo << 1;
      hi = (hi << 1) | 16'd1;
    end
    iv_low  = lo;
    iv_high = hi;
    if (n > 0) begin
      res = code_q.pop_back();
      res.last = 1'b1;
      code_q = {code_q, res};
    end
  endfunction

  task automatic push_sym(input logic [arith_enc_pkg::LowW-1:0]  cl,
                          input logic [arith_enc_pkg::HighW-1:0] ch);
    arith_enc_pkg::in_item_t s;
    s.cum_low  = cl;
    s.cum_high = ch;
    sym_q = {sym_q, s};
  endtask

  // Mostly consistent symbols for the current total, some narrow ones to
  // force long renormalization, the rest raw noise over the full fields.
  task automatic push_random(input int count);
    int unsigned lim;
    int unsigned cl;
    int unsigned ch;
    lim = (total_cfg == '0) ? 1 : total_cfg;
    repeat (count) begin
      if ($urandom_range(99) < 15) begin
        cl = $urandom;
        ch = $urandom;
      end else begin
        cl = $urandom_range((lim > 16384) ? 16383 : lim - 1, 0);
        ch = ($urandom_range(99) < 30) ? cl + 1 : $urandom_range(lim, cl + 1);
      end
      push_sym(cl[arith_enc_pkg::LowW-1:0], ch[arith_enc_pkg::HighW-1:0]);
    end
  endtask

  task automatic set_total(input logic [arith_enc_pkg::TotalW-1:0] val);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we    <= 1'b0;
    total_cfg = val;
  endtask

  // Symbols that emit nothing leave no trace in code_q, so let the core settle.
  task automatic wait_idle();
    do @(negedge clk);
    while (sym_q.size() != 0 || in_valid || code_q.size() != 0);
    repeat (SettleCyc) @(posedge clk);
  endtask

  // symbol driver
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_ready) begin
      if (sym_q.size() != 0 && (calm || $urandom_range(99) >= 13)) begin
        in_valid <= 1'b1;
        in_data  <= sym_q.pop_front();
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      out_ready <= calm || ($urandom_range(99) >= 13);
    end
  end

  // code bit monitor and checker
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      if (code_q.size() == 0) begin
        err_cnt++;
        $display("%0t: unexpected code bit transfer: bit=%0d follow=%0d last=%0d",
                 $time, out_data.code_bit, out_data.follow_count, out_data.last);
      end else begin
        want_item = code_q.pop_front();
        if (out_data.code_bit !== want_item.code_bit ||
            out_data.follow_count !== want_item.follow_count ||
            out_data.last !== want_item.last) begin
          err_cnt++;
          $display("%0t: code bit mismatch:", $time,
                   " expected bit=%0d follow=%0d last=%0d,",
                   want_item.code_bit, want_item.follow_count, want_item.last,
                   " actual bit=%0d follow=%0d last=%0d",
                   out_data.code_bit, out_data.follow_count, out_data.last);
        end
      end
    end
    if (rst_n && in_valid && in_ready) narrow_interval(in_data);
  end

  // watchdog: any transfer restarts the count
  always @(posedge clk) begin
    cyc_cnt <= cyc_cnt + 1;
    if ((in_valid && in_ready) || (out_valid && out_ready)) begin
      stall_cnt <= 0;
    end else begin
      stall_cnt <= stall_cnt + 1;
    end
    if (stall_cnt == StallLimit) begin
      $display("%0t: watchdog: no transfer for %0d cycles", $time, StallLimit);
      $display("DONE: errors detected");
      $finish;
    end
  end

  initial begin
    logic [arith_enc_pkg::TotalW-1:0] rand_totals [7];
    rand_totals[0] = 15'($urandom_range(16384, 1));
    rand_totals[1] = 15'd2;
    rand_totals[2] = 15'd16384;
    rand_totals[3] = 15'($urandom_range(300, 3));
    rand_totals[4] = 15'd32767;
    rand_totals[5] = 15'($urandom_range(16384, 1000));
    rand_totals[6] = 15'd1;

    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    // reset divisor of 1: every product wraps back to the full interval
    @(negedge clk);
    push_sym(14'd0, 15'd1);
    push_sym(14'h3FFF, 15'h7FFF);
    push_sym(14'd0, 15'd0);
    push_sym(14'h3FFF, 15'd0);
    push_sym(14'h2AAA, 15'h5555);
    wait_idle();

    // Middle symbol from the full interval defers 13 bits and restores it;
    // a run of them builds a long follow count.
    set_total(15'd16384);
    @(negedge clk);
    repeat (20) push_sym(14'd8191, 15'd8193);
    push_sym(14'd0, 15'd1);
    push_sym(14'd16383, 15'd16384);
    push_sym(14'd0, 15'd16384);
    push_sym(14'd4096, 15'd12288);
    push_sym(14'd0, 15'd1);
    wait_idle();

    // zero divisor acts as one; inconsistent bounds give wrapped intervals
    set_total(15'd0);
    @(negedge clk);
    push_sym(14'd0, 15'd1);
    push_sym(14'd1, 15'd1);
    push_sym(14'd3, 15'd2);
    push_sym(14'd0, 15'h7FFF);
    wait_idle();

    set_total(15'h7FFF);
    @(negedge clk);
    push_sym(14'h3FFF, 15'h7FFF);
    push_sym(14'd0, 15'd1);
    push_sym(14'd16382, 15'd16383);
    push_sym(14'd16383, 15'd16384);
    wait_idle();

    foreach (rand_totals[i]) begin
      set_total(rand_totals[i]);
      @(negedge clk);
      push_random(35);
      wait_idle();
    end

    if (err_cnt == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
